>>> hdl/ste_pkg.sv
// Shared types and constants for the subscription table engine.
`timescale 1ns / 1ps

package ste_pkg;

  localparam int TABLE_DEPTH_DEF = 8;

  localparam int REQ_W    = 2;
  localparam int NODE_W   = 8;
  localparam int PARAM_W  = 8;
  localparam int SID_W    = 4;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = NODE_W + PARAM_W;
  localparam int SID_LSB  = ENTRY_W - SID_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

>>> hdl/ste_mem.sv
// Entry store with a write port and a registered read port: one write and one registered read per cycle.
`timescale 1ns / 1ps

module ste_mem #(
  parameter int DEPTH = ste_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = 3
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wa,
  input  logic [ste_pkg::ENTRY_W-1:0] wd,
  input  logic                       re,
  input  logic [AW-1:0]              ra,
  output logic [ste_pkg::ENTRY_W-1:0] rd
);

  logic [ste_pkg::ENTRY_W-1:0] mem [0:DEPTH-1];
  logic [ste_pkg::ENTRY_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

>>> hdl/subscription_table_engine.sv
// Top level of the subscription table engine: request sequencer around the entry store.
`timescale 1ns / 1ps
// Usage:
// The input channel carries one request per beat: add, remove by socket id, or list.
// The result channel returns one beat for add and remove, and one beat per stored
// entry for list (or a single empty-list beat); out_last marks the final beat.
// A request is taken only while the sequencer is idle; in_stall is high otherwise.
// Requests of the unused kind are taken and dropped without any result.
// The entry store has a registered read, so the sequencer steps through states:
// each entry scanned passes through a read and a compare state, each entry moved
// down by a remove through a read and a write state, and each listed entry through
// a read and an output state. The next request may be taken while the last result
// still waits in the output register.
// When the receiver stalls, the output register holds its beat and the sequencer waits
// once its next beat is ready. Reset empties the table and drops any pending beat; the
// store contents need no clearing because only entries below the count are ever read.

module subscription_table_engine #(
  parameter int TABLE_DEPTH = ste_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ste_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ste_pkg::NODE_W-1:0]   in_node_byte,
  input  logic [ste_pkg::PARAM_W-1:0]  in_param_byte,
  input  logic [ste_pkg::SID_W-1:0]    in_remove_id,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ste_pkg::STATUS_W-1:0] out_status,
  output logic [ste_pkg::NODE_W-1:0]   out_node,
  output logic [ste_pkg::PARAM_W-1:0]  out_param,
  output logic                         out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SRD  = 8'b00000010,
    S_SCMP = 8'b00000100,
    S_MRD  = 8'b00001000,
    S_MWR  = 8'b00010000,
    S_LRD  = 8'b00100000,
    S_LOUT = 8'b01000000,
    S_RESP = 8'b10000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  idx_inc;
  ste_pkg::req_t                  kind_r, kind_nxt;
  logic [ste_pkg::SID_W-1:0]      sid_r, sid_nxt;
  logic [ste_pkg::ENTRY_W-1:0]    entry_r, entry_nxt;
  ste_pkg::status_t               status_r, status_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [ste_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ste_pkg::NODE_W-1:0]     out_node_r, out_node_nxt;
  logic [ste_pkg::PARAM_W-1:0]    out_param_r, out_param_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           out_free;

  logic                           mem_we;
  logic [AW-1:0]                  mem_wa;
  logic [ste_pkg::ENTRY_W-1:0]    mem_wd;
  logic                           mem_re;
  logic [AW-1:0]                  mem_ra;
  logic [ste_pkg::ENTRY_W-1:0]    mem_rd;

  ste_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .re  (mem_re),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  assign idx_inc  = idx_r + CW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    kind_nxt       = kind_r;
    sid_nxt        = sid_r;
    entry_nxt      = entry_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_node_nxt   = out_node_r;
    out_param_nxt  = out_param_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r[AW-1:0];
    mem_wd         = entry_r;
    mem_re         = 1'b0;
    mem_ra         = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = ste_pkg::req_t'(in_req_type);
          entry_nxt = {in_node_byte, in_param_byte};
          idx_nxt   = '0;
          case (ste_pkg::req_t'(in_req_type))
            ste_pkg::REQ_ADD: begin
              sid_nxt   = in_node_byte[ste_pkg::NODE_W-1 -: ste_pkg::SID_W];
              state_nxt = S_SRD;
            end
            ste_pkg::REQ_REMOVE: begin
              sid_nxt   = in_remove_id;
              state_nxt = S_SRD;
            end
            ste_pkg::REQ_LIST: begin
              if (count_r == '0) begin
                status_nxt = ste_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_LRD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SRD: begin
        if (idx_r != count_r) begin
          mem_re    = 1'b1;
          state_nxt = S_SCMP;
        end else begin
          state_nxt = S_RESP;
          if (kind_r == ste_pkg::REQ_ADD) begin
            if (count_r == CW'(TABLE_DEPTH)) begin
              status_nxt = ste_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_wa     = count_r[AW-1:0];
              count_nxt  = count_r + CW'(1);
              status_nxt = ste_pkg::ST_OK;
            end
          end else begin
            status_nxt = ste_pkg::ST_NOTFOUND;
          end
        end
      end
      S_SCMP: begin
        if (mem_rd[ste_pkg::ENTRY_W-1 -: ste_pkg::SID_W] == sid_r) begin
          if (kind_r == ste_pkg::REQ_ADD) begin
            status_nxt = ste_pkg::ST_DUP;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_MRD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end
      end
      S_MRD: begin
        if (idx_inc != count_r) begin
          mem_re    = 1'b1;
          mem_ra    = idx_inc[AW-1:0];
          state_nxt = S_MWR;
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ste_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_wd    = mem_rd;
        idx_nxt   = idx_inc;
        state_nxt = S_MRD;
      end
      S_LRD: begin
        mem_re    = 1'b1;
        state_nxt = S_LOUT;
      end
      S_LOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ste_pkg::ST_OK;
          out_node_nxt   = mem_rd[ste_pkg::ENTRY_W-1 -: ste_pkg::NODE_W];
          out_param_nxt  = mem_rd[ste_pkg::PARAM_W-1:0];
          out_last_nxt   = (idx_inc == count_r);
          idx_nxt        = idx_inc;
          state_nxt      = (idx_inc == count_r) ? S_IDLE : S_LRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_node_nxt   = '0;
          out_param_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    kind_r       <= kind_nxt;
    sid_r        <= sid_nxt;
    entry_r      <= entry_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_node_r   <= out_node_nxt;
    out_param_r  <= out_param_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_node   = out_node_r;
  assign out_param  = out_param_r;
  assign out_last   = out_last_r;

endmodule

>>> hdl/ste_checker.sv
// Port-level checker for the subscription table engine and its bind statement.
`timescale 1ns / 1ps

module ste_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [ste_pkg::REQ_W-1:0]    in_req_type,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ste_pkg::STATUS_W-1:0] out_status,
  input logic [ste_pkg::NODE_W-1:0]   out_node,
  input logic [ste_pkg::PARAM_W-1:0]  out_param,
  input logic                         out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_node)
      && $stable(out_param) && $stable(out_last))
    else $error("Stalled result beat changed or dropped.");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ste_pkg::ST_OK) |-> out_last)
    else $error("Non-ok result beat is not the last beat.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ste_pkg::ST_OK) |-> (out_node == '0) && (out_param == '0))
    else $error("Non-ok result beat carries entry data.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type != ste_pkg::REQ_NONE) |=> in_stall)
    else $error("Engine took a request without going busy.");

endmodule

bind subscription_table_engine ste_checker u_ste_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_node    (out_node),
  .out_param   (out_param),
  .out_last    (out_last)
);

>>> sim/tb_subscription_table_engine.sv
// Self-checking testbench for the subscription table engine with a built-in table predictor.
`timescale 1ns / 1ps

module tb_subscription_table_engine;

  localparam int DEPTH = ste_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [ste_pkg::NODE_W-1:0]  node_t;
  typedef logic [ste_pkg::PARAM_W-1:0] param_t;
  typedef logic [ste_pkg::SID_W-1:0]   sid_t;

  typedef struct {
    logic [ste_pkg::STATUS_W-1:0] status;
    node_t                        node;
    param_t                       param;
    logic                         last;
  } beat_t;

  typedef struct {
    ste_pkg::req_t    kind;
    node_t            node;
    param_t           param;
    sid_t             rid;
    logic             has_status;
    ste_pkg::status_t status;
  } request_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [ste_pkg::REQ_W-1:0]    in_req_type;
  logic [ste_pkg::NODE_W-1:0]   in_node_byte;
  logic [ste_pkg::PARAM_W-1:0]  in_param_byte;
  logic [ste_pkg::SID_W-1:0]    in_remove_id;
  logic                         out_valid;
  logic                         out_stall;
  logic [ste_pkg::STATUS_W-1:0] out_status;
  logic [ste_pkg::NODE_W-1:0]   out_node;
  logic [ste_pkg::PARAM_W-1:0]  out_param;
  logic                         out_last;

  logic                         row_has_status;
  ste_pkg::status_t             row_status;
  logic                         steady_phase = 1'b0;

  logic [ste_pkg::ENTRY_W-1:0]  sub_entries [0:DEPTH-1];
  int                           sub_count;
  beat_t                        sub_expected [$];
  request_row_t                 directed_rows [$];
  int                           fail_count;
  int                           cycle_count;

  subscription_table_engine #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_node_byte (in_node_byte),
    .in_param_byte(in_param_byte),
    .in_remove_id (in_remove_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_node     (out_node),
    .out_param    (out_param),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void queue_beat(ste_pkg::status_t st, node_t node, param_t param,
                                     logic last);
    beat_t b;
    b.status = st;
    b.node   = node;
    b.param  = param;
    b.last   = last;
    sub_expected.push_back(b);
  endfunction

  // Updates the table copy and queues the beats that one request causes. A typed-in
  // status replaces the predicted one on single-beat results.
  task automatic predict_request(ste_pkg::req_t kind, node_t node, param_t param, sid_t rid,
                                 logic has_status, ste_pkg::status_t fixed_st);
    int               hit;
    int               i;
    ste_pkg::status_t st;
    hit = -1;
    case (kind)
      ste_pkg::REQ_ADD: begin
        for (i = 0; i < sub_count; i++)
          if (hit < 0 && sub_entries[i][ste_pkg::ENTRY_W-1:ste_pkg::SID_LSB] ==
              node[ste_pkg::NODE_W-1:ste_pkg::NODE_W-ste_pkg::SID_W])
            hit = i;
        if (hit >= 0) begin
          st = ste_pkg::ST_DUP;
        end else if (sub_count >= DEPTH) begin
          st = ste_pkg::ST_FULL;
        end else begin
          sub_entries[sub_count] = {node, param};
          sub_count++;
          st = ste_pkg::ST_OK;
        end
        queue_beat(has_status ? fixed_st : st, '0, '0, 1'b1);
      end
      ste_pkg::REQ_REMOVE: begin
        for (i = 0; i < sub_count; i++)
          if (hit < 0 && sub_entries[i][ste_pkg::ENTRY_W-1:ste_pkg::SID_LSB] == rid)
            hit = i;
        if (hit >= 0) begin
          for (i = hit; i + 1 < sub_count; i++)
            sub_entries[i] = sub_entries[i + 1];
          sub_count--;
          st = ste_pkg::ST_OK;
        end else begin
          st = ste_pkg::ST_NOTFOUND;
        end
        queue_beat(has_status ? fixed_st : st, '0, '0, 1'b1);
      end
      ste_pkg::REQ_LIST: begin
        if (sub_count == 0) begin
          queue_beat(has_status ? fixed_st : ste_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < sub_count; i++)
            queue_beat(ste_pkg::ST_OK, sub_entries[i][ste_pkg::ENTRY_W-1:ste_pkg::PARAM_W],
                       sub_entries[i][ste_pkg::PARAM_W-1:0], i == sub_count - 1);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t exp;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.node   = out_node;
        got.param  = out_param;
        got.last   = out_last;
        if (sub_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %0d %02h %02h %0b",
                   $time, got.status, got.node, got.param, got.last);
          fail_count++;
        end else begin
          exp = sub_expected.pop_front();
          if (got.status !== exp.status || got.node !== exp.node ||
              got.param !== exp.param || got.last !== exp.last) begin
            $display("%0t: expected %0d %02h %02h %0b, got %0d %02h %02h %0b",
                     $time, exp.status, exp.node, exp.param, exp.last,
                     got.status, got.node, got.param, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_request(ste_pkg::req_t'(in_req_type), in_node_byte, in_param_byte,
                        in_remove_id, row_has_status, row_status);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = steady_phase ? 0 : int'($urandom_range(0, 7));
      @(negedge clk);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic add_row(ste_pkg::req_t kind, node_t node, param_t param, sid_t rid,
                         logic has_status, ste_pkg::status_t st);
    request_row_t r;
    r.kind       = kind;
    r.node       = node;
    r.param      = param;
    r.rid        = rid;
    r.has_status = has_status;
    r.status     = st;
    directed_rows.push_back(r);
  endtask

  task automatic send_request(request_row_t r);
    int gap;
    gap = steady_phase ? 0 : int'($urandom_range(0, 7));
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type    = r.kind;
    in_node_byte   = r.node;
    in_param_byte  = r.param;
    in_remove_id   = r.rid;
    row_has_status = r.has_status;
    row_status     = r.status;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    request_row_t r;
    int           pick;
    int           add_weight;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = ste_pkg::REQ_NONE;
    in_node_byte   = '0;
    in_param_byte  = '0;
    in_remove_id   = '0;
    row_has_status = 1'b0;
    row_status     = ste_pkg::ST_OK;
    steady_phase   = 1'b0;
    sub_count      = 0;
    fail_count     = 0;
    cycle_count    = 0;

    add_row(ste_pkg::REQ_LIST,   8'h00, 8'h00, 4'h0, 1'b1, ste_pkg::ST_EMPTY);
    add_row(ste_pkg::REQ_REMOVE, 8'h00, 8'h00, 4'h0, 1'b1, ste_pkg::ST_NOTFOUND);
    add_row(ste_pkg::REQ_NONE,   8'hFF, 8'hFF, 4'hF, 1'b0, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h00, 8'h00, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h0F, 8'hFF, 4'h0, 1'b1, ste_pkg::ST_DUP);
    add_row(ste_pkg::REQ_ADD,    8'h1A, 8'h55, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h2B, 8'hAA, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h3C, 8'h0F, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h4D, 8'hF0, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h5E, 8'h81, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h6F, 8'h7E, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'hF0, 8'hFF, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h77, 8'h33, 4'h0, 1'b1, ste_pkg::ST_FULL);
    add_row(ste_pkg::REQ_ADD,    8'hF5, 8'h44, 4'h0, 1'b1, ste_pkg::ST_DUP);
    add_row(ste_pkg::REQ_LIST,   8'h00, 8'h00, 4'h0, 1'b0, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_REMOVE, 8'h00, 8'h00, 4'hF, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_REMOVE, 8'h00, 8'h00, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_REMOVE, 8'h00, 8'h00, 4'h3, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_REMOVE, 8'h00, 8'h00, 4'h3, 1'b1, ste_pkg::ST_NOTFOUND);
    add_row(ste_pkg::REQ_LIST,   8'h00, 8'h00, 4'h0, 1'b0, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_ADD,    8'h70, 8'h01, 4'h0, 1'b1, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_NONE,   8'h00, 8'h00, 4'h0, 1'b0, ste_pkg::ST_OK);
    add_row(ste_pkg::REQ_LIST,   8'h00, 8'h00, 4'h0, 1'b0, ste_pkg::ST_OK);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i]);

    // Phases alternate between filling and draining the table; the middle one runs
    // with no idling on either side.
    for (int phase = 0; phase < 5; phase++) begin
      steady_phase = (phase == 2);
      add_weight = (phase % 2 == 0) ? 55 : 30;
      for (int n = 0; n < 50; n++) begin
        pick = int'($urandom_range(0, 99));
        r.node       = node_t'($urandom_range(0, 255));
        r.param      = param_t'($urandom_range(0, 255));
        r.rid        = sid_t'($urandom_range(0, 15));
        r.has_status = 1'b0;
        r.status     = ste_pkg::ST_OK;
        if (pick < add_weight) begin
          r.kind = ste_pkg::REQ_ADD;
        end else if (pick < 80) begin
          r.kind = ste_pkg::REQ_REMOVE;
          if (sub_count > 0 && $urandom_range(0, 9) < 7)
            r.rid = sub_entries[$urandom_range(0, sub_count - 1)]
                               [ste_pkg::ENTRY_W-1:ste_pkg::SID_LSB];
        end else if (pick < 96) begin
          r.kind = ste_pkg::REQ_LIST;
        end else begin
          r.kind = ste_pkg::REQ_NONE;
        end
        send_request(r);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sub_expected.size() != 0)
      @(posedge clk);
    repeat (4 * DEPTH + 20) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> subscription_table_engine.f
hdl/ste_pkg.sv
hdl/ste_mem.sv
hdl/subscription_table_engine.sv
hdl/ste_checker.sv
sim/tb_subscription_table_engine.sv
